@@ rtl/core/lswhll_pkg.sv @@
// Shared types and constants of the linear shallow water HLL flux block.
package lswhll_pkg;

    localparam int FracBitsDef = 16;

    localparam logic [23:0] GravityRst = 24'd642908;
    localparam logic [31:0] DepthRst   = 32'd65536;

    // signed numerator width of the star flux, quotient bits kept, root bits
    localparam int NumW  = 100;
    localparam int QuotW = 33;
    localparam int RootW = 28;

    localparam logic [7:0] CFG_GRAVITY = 8'd0;
    localparam logic [7:0] CFG_DEPTH   = 8'd1;

    typedef enum logic [1:0] {
        REG_LEFT  = 2'd0,
        REG_RIGHT = 2'd1,
        REG_STAR  = 2'd2
    } t_region;

endpackage

@@ rtl/core/linear_shallow_water_hll_flux.sv @@
// HLL interface flux for the linearized shallow water equations.
//
// One interface point per word, one word per clock. Each word runs through a
// fixed pipeline of 41 stages: product stages, numerator sums, rounding
// offset, then a divider with one quotient bit per stage, and an output
// register. The output register stalls the whole pipeline only while a result
// waits and is not taken. After reset and after every configuration write the
// wave speed sqrt(gravity*depth) is rebuilt by a digit serial root unit;
// during that time the input channel shows not ready.
module linear_shallow_water_hll_flux import lswhll_pkg::*; #(
    parameter int FRAC_BITS = FracBitsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_eta_left,
    input  logic signed [31:0] i_u_left,
    input  logic signed [31:0] i_v_left,
    input  logic signed [31:0] i_eta_right,
    input  logic signed [31:0] i_u_right,
    input  logic signed [31:0] i_v_right,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_mass_flux,
    output logic signed [31:0] o_x_momentum_flux,
    output logic signed [31:0] o_y_momentum_flux,
    output logic [1:0]         o_region,
    output logic               o_saturated
);

    localparam int DenW = 33 + FRAC_BITS;
    localparam logic [DenW-1:0] DenOne = {{(DenW-1){1'b0}}, 1'b1} << FRAC_BITS;

    function automatic logic signed [66:0] mul_hi(logic signed [33:0] hi,
                                                  logic signed [32:0] x);
        mul_hi = hi * x;
    endfunction

    function automatic logic signed [65:0] mul_lo(logic [31:0] lo, logic signed [32:0] x);
        mul_lo = $signed({1'b0, lo}) * x;
    endfunction

    function automatic logic signed [NumW-1:0] join_pp(logic signed [66:0] h,
                                                       logic signed [65:0] l);
        join_pp = (NumW'(h) <<< 32) + NumW'(l);
    endfunction

    // ---------------- configuration and wave speed ----------------
    typedef enum logic [1:0] {SQ_MUL, SQ_ROOT, SQ_IDLE} t_sq_state;

    t_sq_state         r_sq_state;
    logic [23:0]       r_gravity;
    logic [31:0]       r_depth;
    logic [55:0]       r_rad;
    logic [RootW-1:0]  r_root;
    logic [28:0]       r_rem;
    logic [4:0]        r_cnt;
    logic [55:0]       w_rad;
    logic [30:0]       w_trem;
    logic [30:0]       w_trial;
    logic              w_tge;

    assign w_rad   = r_gravity * r_depth;
    assign w_trem  = {r_rem, r_rad[55:54]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_tge   = w_trem >= w_trial;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_state <= SQ_MUL;
            r_gravity  <= GravityRst;
            r_depth    <= DepthRst;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_GRAVITY) begin
                r_gravity <= i_cfg_data[23:0];
            end else if (i_cfg_index == CFG_DEPTH) begin
                r_depth <= i_cfg_data;
            end
            r_sq_state <= SQ_MUL;
        end else begin
            unique case (r_sq_state)
                SQ_MUL: begin
                    r_rad      <= w_rad;
                    r_root     <= '0;
                    r_rem      <= '0;
                    r_cnt      <= 5'(RootW - 1);
                    r_sq_state <= SQ_ROOT;
                end
                SQ_ROOT: begin
                    if (w_tge) begin
                        r_rem  <= 29'(w_trem - w_trial);
                        r_root <= {r_root[RootW-2:0], 1'b1};
                    end else begin
                        r_rem  <= w_trem[28:0];
                        r_root <= {r_root[RootW-2:0], 1'b0};
                    end
                    r_rad <= {r_rad[53:0], 2'b00};
                    if (r_cnt == 5'd0) begin
                        r_sq_state <= SQ_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                SQ_IDLE: begin
                end
                default: r_sq_state <= SQ_MUL;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic w_acc;
    logic r_out_vld;

    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en && (r_sq_state == SQ_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_s6_vld;
    logic r_dv_vld [0:QuotW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k <= QuotW; k++) r_dv_vld[k] <= 1'b0;
        end else if (en) begin
            r_s1_vld    <= w_acc;
            r_s2_vld    <= r_s1_vld;
            r_s3_vld    <= r_s2_vld;
            r_s4_vld    <= r_s3_vld;
            r_s5_vld    <= r_s4_vld;
            r_s6_vld    <= r_s5_vld;
            r_dv_vld[0] <= r_s6_vld;
            for (int k = 0; k < QuotW; k++) r_dv_vld[k+1] <= r_dv_vld[k];
            r_out_vld   <= r_dv_vld[QuotW];
        end
    end

    // ---------------- stage 1: speeds, differences, first products ----------
    logic signed [32:0] w_sl, w_sr;
    logic signed [64:0] w_p1, w_p2;
    logic signed [56:0] w_q1, w_q2;
    t_region            w_reg;

    assign w_sl = $signed({i_u_left[31], i_u_left}) - $signed({5'b0, r_root});
    assign w_sr = $signed({i_u_right[31], i_u_right}) + $signed({5'b0, r_root});
    assign w_p1 = $signed({1'b0, r_depth}) * i_u_left;
    assign w_p2 = $signed({1'b0, r_depth}) * i_u_right;
    assign w_q1 = $signed({1'b0, r_gravity}) * i_eta_left;
    assign w_q2 = $signed({1'b0, r_gravity}) * i_eta_right;

    always_comb begin
        if (!w_sl[32]) begin
            w_reg = REG_LEFT;
        end else if (w_sr[32] || (w_sr == '0)) begin
            w_reg = REG_RIGHT;
        end else begin
            w_reg = REG_STAR;
        end
    end

    logic signed [32:0] r_s1_sl, r_s1_sr, r_s1_deta, r_s1_du, r_s1_dv;
    logic signed [63:0] r_s1_p1, r_s1_p2;
    logic signed [55:0] r_s1_q1, r_s1_q2;
    t_region            r_s1_reg;

    // ---------------- stage 2 ----------------
    logic signed [65:0] w_s2_p3;
    assign w_s2_p3 = r_s1_sl * r_s1_sr;

    logic signed [66:0] r_s2_h1, r_s2_h2, r_s2_h4, r_s2_h5;
    logic signed [65:0] r_s2_l1, r_s2_l2, r_s2_l4, r_s2_l5;
    logic signed [65:0] r_s2_p3;
    logic signed [32:0] r_s2_deta, r_s2_du, r_s2_dv;
    logic [32:0]        r_s2_d;
    logic signed [63:0] r_s2_p1, r_s2_p2;
    logic signed [55:0] r_s2_q1, r_s2_q2;
    t_region            r_s2_reg;
    logic signed [33:0] w_s2_diff;
    assign w_s2_diff = r_s1_sr - r_s1_sl;

    // ---------------- stage 3 ----------------
    logic signed [NumW-1:0] r_s3_t1, r_s3_t2, r_s3_t4, r_s3_t5;
    logic signed [66:0]     r_s3_h3, r_s3_h6, r_s3_h7;
    logic signed [65:0]     r_s3_l3, r_s3_l6, r_s3_l7;
    logic [32:0]            r_s3_d;
    logic signed [63:0]     r_s3_p1, r_s3_p2;
    logic signed [55:0]     r_s3_q1, r_s3_q2;
    t_region                r_s3_reg;

    // ---------------- stage 4 ----------------
    logic signed [NumW-1:0] r_s4_a, r_s4_b, r_s4_t3, r_s4_t6, r_s4_t7;
    logic [32:0]            r_s4_d;
    logic signed [63:0]     r_s4_p1, r_s4_p2;
    logic signed [55:0]     r_s4_q1, r_s4_q2;
    t_region                r_s4_reg;

    // ---------------- stage 5: numerators and denominator ----------------
    logic signed [NumW-1:0] r_s5_num [3];
    logic [DenW-1:0]        r_s5_den;
    t_region                r_s5_reg;

    // ---------------- stage 6: magnitude plus rounding offset --------------
    logic [NumW-1:0] r_s6_mag [3];
    logic            r_s6_neg [3];
    logic [DenW-1:0] r_s6_den;
    t_region         r_s6_reg;
    logic [NumW-1:0] w_abs [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_abs[l] = r_s5_num[l][NumW-1] ? NumW'(-r_s5_num[l]) : r_s5_num[l];
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    logic [DenW-1:0]  r_dv_rem [0:QuotW][3];
    logic [QuotW-1:0] r_dv_low [0:QuotW][3];
    logic [QuotW-1:0] r_dv_q   [0:QuotW][3];
    logic             r_dv_pre [0:QuotW][3];
    logic             r_dv_neg [0:QuotW][3];
    logic [DenW-1:0]  r_dv_den [0:QuotW];
    t_region          r_dv_reg [0:QuotW];
    logic [DenW:0]    w_dv_sh  [QuotW][3];
    logic             w_dv_ge  [QuotW][3];

    always_comb begin
        for (int k = 0; k < QuotW; k++) begin
            for (int l = 0; l < 3; l++) begin
                w_dv_sh[k][l] = {r_dv_rem[k][l], r_dv_low[k][l][QuotW-1]};
                w_dv_ge[k][l] = w_dv_sh[k][l] >= {1'b0, r_dv_den[k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1
            r_s1_sl   <= w_sl;
            r_s1_sr   <= w_sr;
            r_s1_deta <= $signed({i_eta_right[31], i_eta_right})
                       - $signed({i_eta_left[31], i_eta_left});
            r_s1_du   <= $signed({i_u_right[31], i_u_right})
                       - $signed({i_u_left[31], i_u_left});
            r_s1_dv   <= $signed({i_v_right[31], i_v_right})
                       - $signed({i_v_left[31], i_v_left});
            r_s1_p1   <= w_p1[63:0];
            r_s1_p2   <= w_p2[63:0];
            r_s1_q1   <= w_q1[55:0];
            r_s1_q2   <= w_q2[55:0];
            r_s1_reg  <= w_reg;

            // stage 2: 64-bit and 56-bit products split into two halves
            r_s2_h1   <= mul_hi($signed(r_s1_p1[63:32]), r_s1_sr);
            r_s2_l1   <= mul_lo(r_s1_p1[31:0], r_s1_sr);
            r_s2_h2   <= mul_hi($signed(r_s1_p2[63:32]), r_s1_sl);
            r_s2_l2   <= mul_lo(r_s1_p2[31:0], r_s1_sl);
            r_s2_h4   <= mul_hi($signed(r_s1_q1[55:32]), r_s1_sr);
            r_s2_l4   <= mul_lo(r_s1_q1[31:0], r_s1_sr);
            r_s2_h5   <= mul_hi($signed(r_s1_q2[55:32]), r_s1_sl);
            r_s2_l5   <= mul_lo(r_s1_q2[31:0], r_s1_sl);
            r_s2_p3   <= w_s2_p3;
            r_s2_deta <= r_s1_deta;
            r_s2_du   <= r_s1_du;
            r_s2_dv   <= r_s1_dv;
            r_s2_d    <= w_s2_diff[32:0];
            r_s2_p1   <= r_s1_p1;
            r_s2_p2   <= r_s1_p2;
            r_s2_q1   <= r_s1_q1;
            r_s2_q2   <= r_s1_q2;
            r_s2_reg  <= r_s1_reg;

            // stage 3
            r_s3_t1  <= join_pp(r_s2_h1, r_s2_l1);
            r_s3_t2  <= join_pp(r_s2_h2, r_s2_l2);
            r_s3_t4  <= join_pp(r_s2_h4, r_s2_l4);
            r_s3_t5  <= join_pp(r_s2_h5, r_s2_l5);
            r_s3_h3  <= mul_hi(r_s2_p3[65:32], r_s2_deta);
            r_s3_l3  <= mul_lo(r_s2_p3[31:0], r_s2_deta);
            r_s3_h6  <= mul_hi(r_s2_p3[65:32], r_s2_du);
            r_s3_l6  <= mul_lo(r_s2_p3[31:0], r_s2_du);
            r_s3_h7  <= mul_hi(r_s2_p3[65:32], r_s2_dv);
            r_s3_l7  <= mul_lo(r_s2_p3[31:0], r_s2_dv);
            r_s3_d   <= r_s2_d;
            r_s3_p1  <= r_s2_p1;
            r_s3_p2  <= r_s2_p2;
            r_s3_q1  <= r_s2_q1;
            r_s3_q2  <= r_s2_q2;
            r_s3_reg <= r_s2_reg;

            // stage 4
            r_s4_a   <= r_s3_t1 - r_s3_t2;
            r_s4_b   <= r_s3_t4 - r_s3_t5;
            r_s4_t3  <= join_pp(r_s3_h3, r_s3_l3);
            r_s4_t6  <= join_pp(r_s3_h6, r_s3_l6);
            r_s4_t7  <= join_pp(r_s3_h7, r_s3_l7);
            r_s4_d   <= r_s3_d;
            r_s4_p1  <= r_s3_p1;
            r_s4_p2  <= r_s3_p2;
            r_s4_q1  <= r_s3_q1;
            r_s4_q2  <= r_s3_q2;
            r_s4_reg <= r_s3_reg;

            // stage 5
            unique case (r_s4_reg)
                REG_LEFT: begin
                    r_s5_num[0] <= NumW'(r_s4_p1);
                    r_s5_num[1] <= NumW'(r_s4_q1);
                    r_s5_num[2] <= '0;
                    r_s5_den    <= DenOne;
                end
                REG_RIGHT: begin
                    r_s5_num[0] <= NumW'(r_s4_p2);
                    r_s5_num[1] <= NumW'(r_s4_q2);
                    r_s5_num[2] <= '0;
                    r_s5_den    <= DenOne;
                end
                default: begin
                    r_s5_num[0] <= r_s4_a + r_s4_t3;
                    r_s5_num[1] <= r_s4_b + r_s4_t6;
                    r_s5_num[2] <= r_s4_t7;
                    r_s5_den    <= {r_s4_d, {FRAC_BITS{1'b0}}};
                end
            endcase
            r_s5_reg <= r_s4_reg;

            // stage 6: half the divisor gives round half away from zero
            for (int l = 0; l < 3; l++) begin
                r_s6_mag[l] <= w_abs[l] + NumW'(r_s5_den >> 1);
                r_s6_neg[l] <= r_s5_num[l][NumW-1];
            end
            r_s6_den <= r_s5_den;
            r_s6_reg <= r_s5_reg;

            // divider entry: quotients of 2^QuotW or more are clipped anyway
            for (int l = 0; l < 3; l++) begin
                r_dv_pre[0][l] <= r_s6_mag[l] >= NumW'({r_s6_den, {QuotW{1'b0}}});
                r_dv_rem[0][l] <= r_s6_mag[l][QuotW +: DenW];
                r_dv_low[0][l] <= r_s6_mag[l][QuotW-1:0];
                r_dv_q[0][l]   <= '0;
                r_dv_neg[0][l] <= r_s6_neg[l];
            end
            r_dv_den[0] <= r_s6_den;
            r_dv_reg[0] <= r_s6_reg;

            for (int k = 0; k < QuotW; k++) begin
                for (int l = 0; l < 3; l++) begin
                    if (w_dv_ge[k][l]) begin
                        r_dv_rem[k+1][l] <= DenW'(w_dv_sh[k][l] - {1'b0, r_dv_den[k]});
                    end else begin
                        r_dv_rem[k+1][l] <= w_dv_sh[k][l][DenW-1:0];
                    end
                    r_dv_q[k+1][l]   <= {r_dv_q[k][l][QuotW-2:0], w_dv_ge[k][l]};
                    r_dv_low[k+1][l] <= {r_dv_low[k][l][QuotW-2:0], 1'b0};
                    r_dv_pre[k+1][l] <= r_dv_pre[k][l];
                    r_dv_neg[k+1][l] <= r_dv_neg[k][l];
                end
                r_dv_den[k+1] <= r_dv_den[k];
                r_dv_reg[k+1] <= r_dv_reg[k];
            end
        end
    end

    // ---------------- output: sign, clip, register ----------------
    logic [31:0] w_val [3];
    logic        w_sat [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (r_dv_neg[QuotW][l]) begin
                w_sat[l] = r_dv_pre[QuotW][l] || (r_dv_q[QuotW][l] > 33'h080000000);
                w_val[l] = w_sat[l] ? 32'h80000000 : 32'(-r_dv_q[QuotW][l][31:0]);
            end else begin
                w_sat[l] = r_dv_pre[QuotW][l] || (r_dv_q[QuotW][l] > 33'h07FFFFFFF);
                w_val[l] = w_sat[l] ? 32'h7FFFFFFF : r_dv_q[QuotW][l][31:0];
            end
        end
    end

    logic [31:0] r_out_mass, r_out_xm, r_out_ym;
    t_region     r_out_reg;
    logic        r_out_sat;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_mass <= w_val[0];
            r_out_xm   <= w_val[1];
            r_out_ym   <= w_val[2];
            r_out_reg  <= r_dv_reg[QuotW];
            r_out_sat  <= w_sat[0] || w_sat[1] || w_sat[2];
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_mass_flux       = r_out_mass;
    assign o_x_momentum_flux = r_out_xm;
    assign o_y_momentum_flux = r_out_ym;
    assign o_region          = r_out_reg;
    assign o_saturated       = r_out_sat;

endmodule

@@ rtl/core/lswhll_checker.sv @@
// Port level checks of the HLL flux block, bound to its top level.
module lswhll_checker import lswhll_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_mass_flux,
    input logic signed [31:0] o_y_momentum_flux,
    input logic [1:0]         o_region,
    input logic               o_saturated
);

    // a result word waiting at the output holds its mass flux, region and saturation flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_mass_flux)
            && $stable(o_region) && $stable(o_saturated))
        else $error("output word changed while stalled");

    // upwind regions carry no y momentum flux
    a_upwind_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_region == REG_LEFT || o_region == REG_RIGHT)
            |-> o_y_momentum_flux == 32'sd0)
        else $error("nonzero y flux in upwind region");

    // a stalled output blocks new input words
    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted during output stall");

endmodule

bind linear_shallow_water_hll_flux lswhll_checker u_lswhll_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_mass_flux       (o_mass_flux),
    .o_y_momentum_flux (o_y_momentum_flux),
    .o_region          (o_region),
    .o_saturated       (o_saturated)
);
